// ===== rtl/aeskx_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 round key step: shared definitions
// Key word type, direction codes, the AES S-box and the round constant lookup.
// ----------------------------------------------------------------------------
package aeskx_pkg;

  typedef logic [31:0] key_word_t;

  // Direction of one step through the key schedule.
  localparam logic OP_FWD = 1'b0;
  localparam logic OP_INV = 1'b1;

  // Field widths of the input and result words.
  localparam int unsigned KEY_HALF_W = 64;
  localparam int unsigned ROUND_W    = 4;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 128;

  // One registered input word.
  typedef struct packed {
    logic [KEY_HALF_W-1:0] key_high;
    logic [KEY_HALF_W-1:0] key_low;
    logic [ROUND_W-1:0]    round_number;
    logic                  opcode;
  } in_item_t;

  // Standard AES forward S-box.
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant; rounds outside one to ten give zero.
  function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] rnd);
    logic [7:0] rc;
    case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

// ===== rtl/aeskx_core.sv =====
// ----------------------------------------------------------------------------
// AES-128 round key step: core word function
// Rotates a key word left by one byte, substitutes every byte through the
// S-box and adds the round constant into the top byte.
// ----------------------------------------------------------------------------
module aeskx_core (
  input  aeskx_pkg::key_word_t               w,
  input  logic [aeskx_pkg::ROUND_W-1:0]      round_number,
  output aeskx_pkg::key_word_t               t
);

  aeskx_pkg::key_word_t rot;
  aeskx_pkg::key_word_t sub;

  // Byte rotation followed by the four S-box lookups.
  assign rot = {w[23:0], w[31:24]};
  assign sub = {aeskx_pkg::SBOX[rot[31:24]], aeskx_pkg::SBOX[rot[23:16]],
                aeskx_pkg::SBOX[rot[15:8]],  aeskx_pkg::SBOX[rot[7:0]]};

  // Round constant lands in the most significant byte.
  assign t = sub ^ {aeskx_pkg::rcon(round_number), 24'h000000};

endmodule

// ===== rtl/aeskx_step.sv =====
// ----------------------------------------------------------------------------
// AES-128 round key step: one schedule step
// Forward mode derives the next round key, inverse mode the previous one,
// by chaining XORs across the four words around the core word function.
// ----------------------------------------------------------------------------
module aeskx_step (
  input  aeskx_pkg::in_item_t                 item,
  output logic [aeskx_pkg::KEY_HALF_W-1:0]    next_high,
  output logic [aeskx_pkg::KEY_HALF_W-1:0]    next_low
);

  aeskx_pkg::key_word_t w0, w1, w2, w3;
  aeskx_pkg::key_word_t core_in, core_out;
  aeskx_pkg::key_word_t n0, n1, n2, n3;

  assign w0 = item.key_high[63:32];
  assign w1 = item.key_high[31:0];
  assign w2 = item.key_low[63:32];
  assign w3 = item.key_low[31:0];

  // The inverse step feeds the recovered last word of the previous key.
  assign core_in = (item.opcode == aeskx_pkg::OP_INV) ? (w3 ^ w2) : w3;

  aeskx_core u_core (
    .w            (core_in),
    .round_number (item.round_number),
    .t            (core_out)
  );

  // Word chaining for the two directions.
  always_comb begin
    if (item.opcode == aeskx_pkg::OP_INV) begin
      n3 = w3 ^ w2;
      n2 = w2 ^ w1;
      n1 = w1 ^ w0;
      n0 = w0 ^ core_out;
    end else begin
      n0 = w0 ^ core_out;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
    end
  end

  assign next_high = {n0, n1};
  assign next_low  = {n2, n3};

endmodule

// ===== rtl/aes128_round_key_step.sv =====
// ----------------------------------------------------------------------------
// AES-128 round key step: top level
// Registered single-pass key schedule step with stream handshakes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one round key per word, together with the round
//   number and, on in_tuser, the direction (0 forward, 1 inverse). Each input
//   word yields exactly one output word holding the next (forward) or the
//   previous (inverse) round key in the same byte order.
//   An accepted word is held in the input register, then passes through the
//   S-box and XOR chain into the output register, which drives out_tvalid.
//   Throughput is one word per clock while out_tready is high; the rate is set
//   by the single pass of four S-box lookups and the XOR chain between registers.
//   When the receiver holds out_tready low, the output word is held stable
//   and a second word waits in the input register; in_tready falls only when
//   both registers are full. Synchronous reset (rst_n low) empties both
//   registers and holds in_tready low. Nothing is kept between words.
// ----------------------------------------------------------------------------
module aes128_round_key_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // key_high[63:0], key_low[127:64], round_number[131:128], zero fill
  input  logic [aeskx_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[0]
  input  logic                                 in_tuser,
  // Result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // next_high[63:0], next_low[127:64]
  output logic [aeskx_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic                                  in_valid_r, in_valid_nxt;
  aeskx_pkg::in_item_t                   in_item_r, in_item_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [aeskx_pkg::OUT_DATA_W-1:0]      out_data_r, out_data_nxt;
  logic                                  out_free;
  logic                                  in_free;
  logic                                  advance;
  logic [aeskx_pkg::KEY_HALF_W-1:0]      next_high, next_low;

  // Stage readiness: each register may load when empty or draining.
  assign out_free  = !out_valid_r || out_tready;
  assign in_free   = !in_valid_r || out_free;
  assign in_tready = rst_n && in_free;
  assign advance   = in_valid_r && out_free;

  // Input register loads the word that arrives.
  always_comb begin
    in_valid_nxt = in_valid_r;
    in_item_nxt  = in_item_r;
    if (in_free) begin
      in_valid_nxt              = in_tvalid;
      in_item_nxt.key_high      = in_tdata[63:0];
      in_item_nxt.key_low       = in_tdata[127:64];
      in_item_nxt.round_number  = in_tdata[131:128];
      in_item_nxt.opcode        = in_tuser;
    end
  end

  aeskx_step u_step (
    .item      (in_item_r),
    .next_high (next_high),
    .next_low  (next_low)
  );

  // Output register takes the computed key when it moves on.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = in_valid_r;
    end
    if (advance) begin
      out_data_nxt = {next_low, next_high};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/aeskx_checker.sv =====
// ----------------------------------------------------------------------------
// AES-128 round key step: port checker
// Concurrent checks on the top level's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module aeskx_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [aeskx_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A ready receiver never blocks the input side.
  a_ready_flow: assert property (@(posedge clk)
    rst_n && out_tready |-> in_tready)
    else $error("input stalled while receiver ready");

  // An accepted word reaches the output when the receiver keeps up.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted word did not reach the output");

endmodule

bind aes128_round_key_step aeskx_checker u_aeskx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/aes128_round_key_step_checker.sv =====
// ----------------------------------------------------------------------------
// AES-128 round key step: result checker
// Watches both stream channels of the key step. Each accepted input word is
// turned into the expected next or previous round key by an independent
// model: the S-box is built from the GF(2^8) inverse and the affine map, and
// the round constants come from repeated doubling. Each accepted output word
// is compared field by field with the oldest expected key.
// ----------------------------------------------------------------------------
module aes128_round_key_step_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [aeskx_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [aeskx_pkg::OUT_DATA_W-1:0]  out_tdata,
  output int                                fail_count,
  output int                                pending
);

  // One round key as it leaves the block.
  typedef struct packed {
    logic [aeskx_pkg::KEY_HALF_W-1:0] next_high;
    logic [aeskx_pkg::KEY_HALF_W-1:0] next_low;
  } round_key_t;

  round_key_t expected_keys[$];
  logic [7:0] sub_byte [256];

  // Multiplication in GF(2^8) modulo the AES polynomial.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] acc;
    prod = 8'h00;
    acc  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        prod ^= acc;
      end
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1b : 8'h00);
    end
    return prod;
  endfunction

  // The S-box: multiplicative inverse (zero maps to zero), then the affine map.
  initial begin : build_sub_bytes
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) begin
        inv = gf_mul(inv, x[7:0]);
      end
      sub_byte[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                  ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  end

  // Round constant: powers of two in GF(2^8) for rounds one to ten, else zero.
  function automatic logic [7:0] round_const(input logic [aeskx_pkg::ROUND_W-1:0] rnd);
    logic [7:0] rc;
    rc = 8'h00;
    if (rnd >= 4'd1 && rnd <= 4'd10) begin
      rc = 8'h01;
      for (int i = 1; i < rnd; i++) begin
        rc = gf_mul(rc, 8'h02);
      end
    end
    return rc;
  endfunction

  // Rotate left by one byte, substitute each byte, add the round constant.
  function automatic aeskx_pkg::key_word_t schedule_core(input aeskx_pkg::key_word_t w,
                                                         input logic [7:0] rc);
    aeskx_pkg::key_word_t rot;
    rot = {w[23:0], w[31:24]};
    return {sub_byte[rot[31:24]] ^ rc, sub_byte[rot[23:16]],
            sub_byte[rot[15:8]], sub_byte[rot[7:0]]};
  endfunction

  // Next round key (forward) or previous round key (inverse).
  function automatic round_key_t step_round_key(
    input logic [aeskx_pkg::KEY_HALF_W-1:0] key_high,
    input logic [aeskx_pkg::KEY_HALF_W-1:0] key_low,
    input logic [aeskx_pkg::ROUND_W-1:0]    rnd,
    input logic                             dir
  );
    aeskx_pkg::key_word_t w0, w1, w2, w3;
    aeskx_pkg::key_word_t n0, n1, n2, n3;
    logic [7:0]           rc;
    round_key_t           res;
    {w0, w1} = key_high;
    {w2, w3} = key_low;
    rc = round_const(rnd);
    if (dir == aeskx_pkg::OP_FWD) begin
      n0 = w0 ^ schedule_core(w3, rc);
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
    end else begin
      n3 = w3 ^ w2;
      n2 = w2 ^ w1;
      n1 = w1 ^ w0;
      n0 = w0 ^ schedule_core(n3, rc);
    end
    res.next_high = {n0, n1};
    res.next_low  = {n2, n3};
    return res;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Predict on every accepted input word, compare on every accepted output word.
  always @(posedge clk) begin
    round_key_t exp_key;
    if (!rst_n) begin
      expected_keys.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_keys.push_back(step_round_key(in_tdata[63:0], in_tdata[127:64],
                                               in_tdata[131:128], in_tuser));
      end
      if (out_tvalid && out_tready) begin
        if (expected_keys.size() == 0) begin
          report_mismatch($sformatf("unexpected output word %h", out_tdata));
        end else begin
          exp_key = expected_keys.pop_front();
          if (out_tdata[63:0] !== exp_key.next_high) begin
            report_mismatch($sformatf("next_high got %h expected %h",
                                      out_tdata[63:0], exp_key.next_high));
          end
          if (out_tdata[127:64] !== exp_key.next_low) begin
            report_mismatch($sformatf("next_low got %h expected %h",
                                      out_tdata[127:64], exp_key.next_low));
          end
        end
      end
    end
    pending = expected_keys.size();
  end

endmodule

// ===== tb/aes128_round_key_step_tb.sv =====
// ----------------------------------------------------------------------------
// AES-128 round key step: testbench top
// Drives round keys into the key step with random idling on the input side
// and random stalls on the output side, in three phases of back pressure.
// A directed set covers the published key schedule, every round number and
// both directions; random keys follow. The checker predicts and compares.
// ----------------------------------------------------------------------------
module aes128_round_key_step_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 260;

  // Cipher key of the published example and its tenth round key.
  localparam logic [63:0] EXAMPLE_KEY_HIGH = 64'h2b7e1516_28aed2a6;
  localparam logic [63:0] EXAMPLE_KEY_LOW  = 64'habf71588_09cf4f3c;
  localparam logic [63:0] EXAMPLE_R10_HIGH = 64'hd014f9a8_c9ee2589;
  localparam logic [63:0] EXAMPLE_R10_LOW  = 64'he13f0cc8_b6630ca6;

  typedef logic [aeskx_pkg::ROUND_W-1:0] round_num_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [aeskx_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = aeskx_pkg::OP_FWD;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [aeskx_pkg::OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  aes128_round_key_step u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  aes128_round_key_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock, period of four units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** aes128_round_key_step: FAILED **");
      $finish;
    end
  end

  // Receiver: stalls at random according to the current phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one word: random idle cycles first, then hold until accepted.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_key(input logic [63:0] key_high, input logic [63:0] key_low,
                          input round_num_t rnd, input logic dir);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, rnd, key_low, key_high};
    in_tuser  <= dir;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every expected word has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Random half key: mostly dense random, sometimes solid or a single bit.
  function automatic logic [63:0] random_half();
    logic [63:0] v;
    case ($urandom_range(9))
      0:       v = {64{1'($urandom_range(1))}};
      1:       v = 64'd1 << $urandom_range(63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_random_keys(input int count);
    round_num_t rnd;
    for (int i = 0; i < count; i++) begin
      // Mostly legal rounds, now and then any four-bit value.
      if ($urandom_range(4) == 0) begin
        rnd = round_num_t'($urandom_range(15));
      end else begin
        rnd = round_num_t'($urandom_range(10, 1));
      end
      send_key(random_half(), random_half(), rnd,
               ($urandom_range(1) == 0) ? aeskx_pkg::OP_FWD : aeskx_pkg::OP_INV);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: sender idles a little, receiver stalls a lot.
    send_idle_pct = 17;
    recv_idle_pct = 83;

    // Every round number forward from the example key, out-of-range ones too.
    for (int r = 0; r < 16; r++) begin
      send_key(EXAMPLE_KEY_HIGH, EXAMPLE_KEY_LOW, round_num_t'(r), aeskx_pkg::OP_FWD);
    end
    // Step back from the last round key, with legal and out-of-range rounds.
    send_key(EXAMPLE_R10_HIGH, EXAMPLE_R10_LOW, 4'd10, aeskx_pkg::OP_INV);
    send_key(EXAMPLE_R10_HIGH, EXAMPLE_R10_LOW, 4'd0, aeskx_pkg::OP_INV);
    send_key(EXAMPLE_R10_HIGH, EXAMPLE_R10_LOW, 4'd15, aeskx_pkg::OP_INV);
    // Extreme keys in both directions.
    send_key('0, '0, 4'd1, aeskx_pkg::OP_FWD);
    send_key('1, '1, 4'd10, aeskx_pkg::OP_FWD);
    send_key('0, '0, 4'd10, aeskx_pkg::OP_INV);
    send_key('1, '1, 4'd1, aeskx_pkg::OP_INV);

    send_random_keys(RANDOM_WORDS);
    drain_results();

    // Phase two: sender idles a lot, receiver stalls a little.
    send_idle_pct = 83;
    recv_idle_pct = 17;
    send_random_keys(RANDOM_WORDS);
    drain_results();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_keys(RANDOM_WORDS);
    drain_results();

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("** aes128_round_key_step: PASSED **");
    end else begin
      $display("** aes128_round_key_step: FAILED **");
    end
    $finish;
  end

endmodule
